// File: design/nirx_pkg.sv
// ----------------------------------------------------------------------------
// nirx_pkg
// Types and constants shared by the NEC IR frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package nirx_pkg;

    localparam int TICK_W     = 8;
    localparam int FRAME_W    = 32;
    localparam int COUNT_W    = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [COUNT_W-1:0] FULL_FRAME_BITS = 6'd32;

    // receiver mode, as reported in rx_state
    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_RECV = 2'd1,
        MODE_DONE = 2'd2
    } mode_t;

    // request kinds
    localparam logic REQ_EDGE    = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE_MIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_MIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_MAX     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_MIN      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_MAX      = 3'd5;

    // register reset values
    localparam logic [TICK_W-1:0] RST_PREAMBLE_MIN = 8'd180;
    localparam logic [TICK_W-1:0] RST_PREAMBLE_MAX = 8'd243;
    localparam logic [TICK_W-1:0] RST_ZERO_MIN     = 8'd14;
    localparam logic [TICK_W-1:0] RST_ZERO_MAX     = 8'd20;
    localparam logic [TICK_W-1:0] RST_ONE_MIN      = 8'd29;
    localparam logic [TICK_W-1:0] RST_ONE_MAX      = 8'd41;

    typedef struct packed {
        logic [TICK_W-1:0] preamble_min;
        logic [TICK_W-1:0] preamble_max;
        logic [TICK_W-1:0] zero_min;
        logic [TICK_W-1:0] zero_max;
        logic [TICK_W-1:0] one_min;
        logic [TICK_W-1:0] one_max;
    } windows_t;

    typedef struct packed {
        logic              req_type;
        logic [TICK_W-1:0] interval_ticks;
        logic              timer_overflow;
    } edge_item_t;

    typedef struct packed {
        logic [1:0]         rx_state;
        logic [FRAME_W-1:0] frame_word;
        logic [COUNT_W-1:0] bits_received;
    } result_t;

    function automatic logic in_window(
        input logic [TICK_W-1:0] t,
        input logic [TICK_W-1:0] lo,
        input logic [TICK_W-1:0] hi
    );
        return (t >= lo) && (t <= hi);
    endfunction

endpackage

`default_nettype wire

// File: design/nirx_if.sv
// ----------------------------------------------------------------------------
// nirx interfaces
// Valid/ready channels for edge items, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface nirx_edge_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] interval_ticks;
    logic       timer_overflow;

    modport source (output valid, req_type, interval_ticks, timer_overflow, input ready);
    modport sink   (input valid, req_type, interval_ticks, timer_overflow, output ready);
endinterface

interface nirx_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  rx_state;
    logic [31:0] frame_word;
    logic [5:0]  bits_received;

    modport source (output valid, rx_state, frame_word, bits_received, input ready);
    modport sink   (input valid, rx_state, frame_word, bits_received, output ready);
endinterface

interface nirx_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: design/nirx_cfg_regs.sv
// ----------------------------------------------------------------------------
// nirx_cfg_regs
// Tick window registers, written through the register write channel.
// ----------------------------------------------------------------------------
`default_nettype none

module nirx_cfg_regs
    import nirx_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  wr_en,
    input  wire logic [CFG_IDX_W-1:0]  wr_index,
    input  wire logic [CFG_DATA_W-1:0] wr_data,
    output windows_t                   windows
);

    windows_t win_reg;
    windows_t win_next;

    always_comb
    begin
        win_next = win_reg;
        if (wr_en)
        begin
            case (wr_index)
                CFG_PREAMBLE_MIN: win_next.preamble_min = wr_data;
                CFG_PREAMBLE_MAX: win_next.preamble_max = wr_data;
                CFG_ZERO_MIN:     win_next.zero_min     = wr_data;
                CFG_ZERO_MAX:     win_next.zero_max     = wr_data;
                CFG_ONE_MIN:      win_next.one_min      = wr_data;
                CFG_ONE_MAX:      win_next.one_max      = wr_data;
                default:          win_next = win_reg; // unmapped index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg.preamble_min <= RST_PREAMBLE_MIN;
            win_reg.preamble_max <= RST_PREAMBLE_MAX;
            win_reg.zero_min     <= RST_ZERO_MIN;
            win_reg.zero_max     <= RST_ZERO_MAX;
            win_reg.one_min      <= RST_ONE_MIN;
            win_reg.one_max      <= RST_ONE_MAX;
        end
        else
        begin
            win_reg <= win_next;
        end
    end

    assign windows = win_reg;

endmodule

`default_nettype wire

// File: design/nirx_decode.sv
// ----------------------------------------------------------------------------
// nirx_decode
// Input register, receiver state and interval classification.
// ----------------------------------------------------------------------------
`default_nettype none

module nirx_decode
    import nirx_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire edge_item_t in_item,
    input  wire windows_t   windows,
    input  wire logic       q_full,
    output logic            push,
    output result_t         push_data
);

    logic               s1_valid_reg;
    edge_item_t         s1_item_reg;
    mode_t              mode_reg;
    mode_t              mode_next;
    logic [FRAME_W-1:0] shift_reg;
    logic [FRAME_W-1:0] shift_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    logic advance;
    logic tick_ok;
    logic hit_pre;
    logic hit_one;
    logic hit_zero;

    assign advance  = s1_valid_reg && !q_full;
    assign in_ready = !s1_valid_reg || !q_full;

    assign tick_ok  = !s1_item_reg.timer_overflow;
    assign hit_pre  = tick_ok && in_window(s1_item_reg.interval_ticks,
                                           windows.preamble_min, windows.preamble_max);
    assign hit_one  = tick_ok && in_window(s1_item_reg.interval_ticks,
                                           windows.one_min, windows.one_max);
    assign hit_zero = tick_ok && in_window(s1_item_reg.interval_ticks,
                                           windows.zero_min, windows.zero_max);

    always_comb
    begin
        mode_next  = mode_reg;
        shift_next = shift_reg;
        count_next = count_reg;
        if (s1_item_reg.req_type == REQ_RELEASE)
        begin
            mode_next = MODE_IDLE;
        end
        else
        begin
            case (mode_reg)
                MODE_IDLE:
                begin
                    if (hit_pre)
                    begin
                        count_next = '0;
                        mode_next  = MODE_RECV;
                    end
                end
                MODE_RECV:
                begin
                    // one window wins where the windows overlap
                    shift_next = {shift_reg[FRAME_W-2:0], hit_one};
                    if (hit_one || hit_zero)
                    begin
                        count_next = count_reg + COUNT_W'(1);
                        if (count_next == FULL_FRAME_BITS)
                        begin
                            mode_next = (shift_next[7:0] == ~shift_next[15:8]) ?
                                        MODE_DONE : MODE_IDLE;
                        end
                    end
                    else
                    begin
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_DONE:
                begin
                    mode_next = MODE_DONE;
                end
                default:
                begin
                    mode_next = MODE_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            mode_reg     <= MODE_IDLE;
            shift_reg    <= '0;
            count_reg    <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                mode_reg  <= mode_next;
                shift_reg <= shift_next;
                count_reg <= count_next;
            end
        end
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_item_reg <= in_item;
        end
    end

    assign push                    = advance;
    assign push_data.rx_state      = mode_next;
    assign push_data.frame_word    = shift_next;
    assign push_data.bits_received = count_next;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_FRAME_BITS)
        else $error("bit count above a full frame");

    a_done_full: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_DONE |-> count_reg == FULL_FRAME_BITS)
        else $error("frame done without a full frame");

    a_release_idle: assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_item_reg.req_type == REQ_RELEASE |=> mode_reg == MODE_IDLE)
        else $error("release did not return to idle");

    a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(shift_reg) && $stable(count_reg))
        else $error("receiver state moved without an item");

endmodule

`default_nettype wire

// File: design/nirx_result_fifo.sv
// ----------------------------------------------------------------------------
// nirx_result_fifo
// Two-entry result queue between the decoder and the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module nirx_result_fifo
    import nirx_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire result_t push_data,
    output logic         full,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_data
);

    result_t    mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       pop;

    assign full      = (count_reg == 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    assign out_data  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("result pushed into a full queue");

    a_count_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd1) == (wr_ptr_reg != rd_ptr_reg))
        else $error("queue pointers disagree with count");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");

endmodule

`default_nettype wire

// File: design/nec_ir_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// nec_ir_frame_receiver_unit
// NEC IR frame receiver: classifies falling-edge intervals and builds frames.
//
//   channel  modport  carries
//   -------  -------  -------------------------------------------------------
//   evt      sink     req_type, interval_ticks, timer_overflow
//   res      source   rx_state, frame_word, bits_received (one per item)
//   cfg      sink     index, data (tick window registers 0..5, always ready)
//
// One item a cycle sustained while the result channel takes results; a result
// passes the input register, then decode into the two-entry result queue.
// A stalled result channel fills the queue, then the input register, then
// drops evt.ready; nothing is lost.
// rst_n clears receiver state to idle, frame and count to zero, windows to
// their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module nec_ir_frame_receiver_unit
    import nirx_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    nirx_edge_if.sink     evt,
    nirx_result_if.source res,
    nirx_cfg_if.sink      cfg
);

    windows_t   windows;
    edge_item_t in_item;
    result_t    push_data;
    result_t    out_data;
    logic       push;
    logic       q_full;

    assign cfg.ready = 1'b1;

    assign in_item.req_type       = evt.req_type;
    assign in_item.interval_ticks = evt.interval_ticks;
    assign in_item.timer_overflow = evt.timer_overflow;

    nirx_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .windows  (windows)
    );

    nirx_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (evt.valid),
        .in_ready  (evt.ready),
        .in_item   (in_item),
        .windows   (windows),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    nirx_result_fifo u_result_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .out_data  (out_data)
    );

    assign res.rx_state      = out_data.rx_state;
    assign res.frame_word    = out_data.frame_word;
    assign res.bits_received = out_data.bits_received;

endmodule

`default_nettype wire

// File: bench/tb_nec_ir_frame_receiver_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nec_ir_frame_receiver_unit
// Self-checking bench for the NEC IR frame receiver. A queue-fed driver offers
// edge and release items with random gaps. A monitor with random stalls checks
// every result against an in-bench model of the receiver. The tick windows are
// moved between phases: defaults, random, widest, empty and overlapping.
// ----------------------------------------------------------------------------

module tb_nec_ir_frame_receiver_unit;
    import nirx_pkg::*;

    localparam int LONG_HOLD      = 64;
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 1000;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    nirx_edge_if   evt_if ();
    nirx_result_if res_if ();
    nirx_cfg_if    cfg_if ();

    // bench-side drive registers, known from time zero
    logic                  send_valid   = 1'b0;
    edge_item_t            send_item    = '0;
    logic                  result_ready = 1'b0;
    logic                  cfg_valid    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = CFG_PREAMBLE_MIN;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    assign evt_if.valid          = send_valid;
    assign evt_if.req_type       = send_item.req_type;
    assign evt_if.interval_ticks = send_item.interval_ticks;
    assign evt_if.timer_overflow = send_item.timer_overflow;
    assign res_if.ready          = result_ready;
    assign cfg_if.valid          = cfg_valid;
    assign cfg_if.index          = cfg_index;
    assign cfg_if.data           = cfg_data;

    nec_ir_frame_receiver_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt_if),
        .res   (res_if),
        .cfg   (cfg_if)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // receiver model state and its copy of the windows
    windows_t    win      = '{RST_PREAMBLE_MIN, RST_PREAMBLE_MAX, RST_ZERO_MIN,
                              RST_ZERO_MAX, RST_ONE_MIN, RST_ONE_MAX};
    mode_t       rx_mode  = MODE_IDLE;
    logic [31:0] rx_shift = '0;
    logic [5:0]  rx_count = '0;

    edge_item_t  pending_items[$];
    result_t     expected_results[$];

    bit          offering     = 1'b0;
    bit          no_idle      = 1'b0;
    int unsigned gap_left     = 0;
    int unsigned stall_left   = 0;
    int unsigned holds_asked  = 0;
    int unsigned holds_done   = 0;
    int unsigned items_queued = 0;
    int unsigned items_sent   = 0;
    int unsigned results_seen = 0;
    int unsigned frames_done  = 0;
    int unsigned errors       = 0;
    int unsigned quiet_cycles = 0;

    function automatic logic tick_fits(input logic [7:0] t, input logic [7:0] lo,
                                       input logic [7:0] hi);
        return (t >= lo) && (t <= hi);
    endfunction

    function automatic result_t advance_receiver(input edge_item_t it);
        result_t r;
        logic    good;
        good = !it.timer_overflow;
        if (it.req_type == REQ_RELEASE)
            rx_mode = MODE_IDLE;
        else if (rx_mode == MODE_IDLE)
        begin
            if (good && tick_fits(it.interval_ticks, win.preamble_min, win.preamble_max))
            begin
                rx_count = '0;
                rx_mode  = MODE_RECV;
            end
        end
        else if (rx_mode == MODE_RECV)
        begin
            rx_shift = rx_shift << 1;
            // one window has priority where the two overlap
            if (good && tick_fits(it.interval_ticks, win.one_min, win.one_max))
            begin
                rx_shift[0] = 1'b1;
                rx_count    = rx_count + 6'd1;
            end
            else if (good && tick_fits(it.interval_ticks, win.zero_min, win.zero_max))
                rx_count = rx_count + 6'd1;
            else
                rx_mode = MODE_IDLE;
            if (rx_mode == MODE_RECV && rx_count == FULL_FRAME_BITS)
            begin
                if (rx_shift[7:0] == ~rx_shift[15:8])
                    rx_mode = MODE_DONE;
                else
                    rx_mode = MODE_IDLE;
            end
        end
        else if (rx_mode != MODE_DONE)
            rx_mode = MODE_IDLE;
        r.rx_state      = rx_mode;
        r.frame_word    = rx_shift;
        r.bits_received = rx_count;
        return r;
    endfunction

    // ---------------- stimulus helpers ----------------

    task automatic queue_edge(input logic req, input logic [7:0] ticks, input logic ovf);
        edge_item_t it;
        it.req_type       = req;
        it.interval_ticks = ticks;
        it.timer_overflow = ovf;
        pending_items.push_back(it);
        items_queued++;
    endtask

    function automatic logic [7:0] pick_tick(input logic [7:0] lo, input logic [7:0] hi);
        return 8'($urandom_range(hi, lo));
    endfunction

    // a tick that lands in neither bit window, where one can be found
    function automatic logic [7:0] stray_tick();
        logic [7:0] t;
        t = 8'($urandom_range(255, 0));
        for (int n = 0; n < 16 && (tick_fits(t, win.one_min, win.one_max) ||
                                   tick_fits(t, win.zero_min, win.zero_max)); n++)
            t = 8'($urandom_range(255, 0));
        return t;
    endfunction

    task automatic queue_frame(input bit whole);
        logic [31:0] word;
        int          nbits;
        word = $urandom;
        if (whole)
        begin
            nbits = 32;
            if ($urandom_range(9, 0) != 0)
                word[7:0] = ~word[15:8];
        end
        else
            nbits = $urandom_range(31, 0);
        queue_edge(REQ_EDGE, pick_tick(win.preamble_min, win.preamble_max), 1'b0);
        for (int i = 31; i >= 32 - nbits; i--)
        begin
            if (word[i])
                queue_edge(REQ_EDGE, pick_tick(win.one_min, win.one_max), 1'b0);
            else
                queue_edge(REQ_EDGE, pick_tick(win.zero_min, win.zero_max), 1'b0);
        end
        if (whole)
        begin
            // edges while done should be ignored
            repeat ($urandom_range(2, 0))
                queue_edge(REQ_EDGE, 8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)));
            if ($urandom_range(9, 0) != 0)
                queue_edge(REQ_RELEASE, 8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)));
        end
        else
        begin
            case ($urandom_range(3, 0))
                0: queue_edge(REQ_EDGE, stray_tick(), 1'b0);
                1: queue_edge(REQ_EDGE, pick_tick(win.one_min, win.one_max), 1'b1);
                2: queue_edge(REQ_RELEASE, 8'($urandom_range(255, 0)), 1'b0);
                default: queue_edge(REQ_EDGE, pick_tick(win.zero_min, win.zero_max), 1'b1);
            endcase
        end
    endtask

    task automatic queue_random(input int unsigned count);
        int unsigned start;
        int unsigned pick;
        start = items_queued;
        while (items_queued - start < count)
        begin
            pick = $urandom_range(99, 0);
            if (pick < 70)
                queue_frame(1'b1);
            else if (pick < 85)
                queue_frame(1'b0);
            else
                queue_edge(1'($urandom_range(1, 0)), 8'($urandom_range(255, 0)),
                           1'($urandom_range(1, 0)));
        end
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || offering || expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_window(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!(cfg_if.valid && cfg_if.ready));
        cfg_valid <= 1'b0;
        case (idx)
            CFG_PREAMBLE_MIN: win.preamble_min = value;
            CFG_PREAMBLE_MAX: win.preamble_max = value;
            CFG_ZERO_MIN:     win.zero_min     = value;
            CFG_ZERO_MAX:     win.zero_max     = value;
            CFG_ONE_MIN:      win.one_min      = value;
            CFG_ONE_MAX:      win.one_max      = value;
            default: ;
        endcase
    endtask

    task automatic set_windows(input logic [7:0] pmin, input logic [7:0] pmax,
                               input logic [7:0] zmin, input logic [7:0] zmax,
                               input logic [7:0] omin, input logic [7:0] omax);
        write_window(CFG_PREAMBLE_MIN, pmin);
        write_window(CFG_PREAMBLE_MAX, pmax);
        write_window(CFG_ZERO_MIN, zmin);
        write_window(CFG_ZERO_MAX, zmax);
        write_window(CFG_ONE_MIN, omin);
        write_window(CFG_ONE_MAX, omax);
    endtask

    // ---------------- edge item driver ----------------

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            offering = 1'b0;
            gap_left = 0;
            send_valid <= 1'b0;
        end
        else
        begin
            if (send_valid && evt_if.ready)
            begin
                expected_results.push_back(advance_receiver(send_item));
                items_sent++;
                offering = 1'b0;
                gap_left = no_idle ? 0 : $urandom_range(7, 0);
            end
            if (!offering)
            begin
                if (gap_left != 0)
                    gap_left--;
                else if (pending_items.size() != 0)
                begin
                    send_item <= pending_items.pop_front();
                    offering = 1'b1;
                end
            end
            send_valid <= offering;
        end
    end

    // ---------------- result monitor ----------------

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            stall_left = 0;
            result_ready <= 1'b0;
        end
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                got.rx_state      = res_if.rx_state;
                got.frame_word    = res_if.frame_word;
                got.bits_received = res_if.bits_received;
                results_seen++;
                if (got.rx_state == MODE_DONE)
                    frames_done++;
                if (expected_results.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: result with none pending: state %0d word %h bits %0d",
                                 $realtime, got.rx_state, got.frame_word, got.bits_received);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.rx_state !== want.rx_state || got.frame_word !== want.frame_word ||
                        got.bits_received !== want.bits_received)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("%0t: mismatch: exp state %0d word %h bits %0d, got %0d %h %0d",
                                     $realtime, want.rx_state, want.frame_word,
                                     want.bits_received, got.rx_state, got.frame_word,
                                     got.bits_received);
                    end
                end
                stall_left = no_idle ? 0 : $urandom_range(7, 0);
            end
            if (holds_done != holds_asked)
            begin
                holds_done = holds_asked;
                stall_left = LONG_HOLD;
            end
            if (stall_left != 0)
            begin
                stall_left--;
                result_ready <= 1'b0;
            end
            else
                result_ready <= 1'b1;
        end
    end

    // ---------------- watchdog ----------------

    always @(posedge clk)
    begin
        if (!rst_n || (evt_if.valid && evt_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $realtime, WATCHDOG_LIMIT);
            $display("FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ---------------- test sequence ----------------

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // short directed run on the reset windows
        queue_edge(REQ_EDGE, 8'd0, 1'b0);        // idle, no preamble
        queue_edge(REQ_EDGE, 8'd255, 1'b0);
        queue_edge(REQ_EDGE, 8'd180, 1'b1);      // overflowed preamble starts nothing
        queue_edge(REQ_RELEASE, 8'd0, 1'b0);     // release while idle
        queue_edge(REQ_EDGE, 8'd180, 1'b0);      // preamble at lower bound
        queue_edge(REQ_EDGE, 8'd41, 1'b0);
        queue_edge(REQ_EDGE, 8'd29, 1'b0);
        queue_edge(REQ_EDGE, 8'd14, 1'b0);
        queue_edge(REQ_EDGE, 8'd20, 1'b0);
        queue_edge(REQ_EDGE, 8'd35, 1'b1);       // overflow aborts, shift still happens
        queue_edge(REQ_EDGE, 8'd200, 1'b0);      // new preamble clears the count
        queue_edge(REQ_EDGE, 8'd30, 1'b0);
        queue_edge(REQ_EDGE, 8'd21, 1'b0);       // between windows: abort
        queue_edge(REQ_EDGE, 8'd243, 1'b0);      // preamble at upper bound
        queue_edge(REQ_EDGE, 8'd16, 1'b0);
        queue_edge(REQ_RELEASE, 8'd255, 1'b1);   // release mid-frame
        queue_edge(REQ_EDGE, 8'd244, 1'b0);
        queue_edge(REQ_EDGE, 8'd179, 1'b0);
        queue_edge(REQ_EDGE, 8'd255, 1'b1);
        queue_edge(REQ_RELEASE, 8'd128, 1'b1);
        queue_random(300);
        wait_drained();

        // random, non-overlapping windows
        begin
            logic [7:0] zmin;
            logic [7:0] zmax;
            logic [7:0] omin;
            logic [7:0] pmin;
            zmin = 8'($urandom_range(30, 5));
            zmax = zmin + 8'($urandom_range(10, 0));
            omin = zmax + 8'd1 + 8'($urandom_range(10, 0));
            pmin = 8'($urandom_range(200, 120));
            set_windows(pmin, pmin + 8'($urandom_range(55, 0)), zmin, zmax,
                        omin, omin + 8'($urandom_range(15, 0)));
        end
        queue_random(200);
        wait_drained();

        // widest preamble window, one bit only at the top tick
        set_windows(8'd0, 8'd255, 8'd0, 8'd254, 8'd255, 8'd255);
        queue_random(150);
        wait_drained();

        // every window empty
        set_windows(8'd255, 8'd0, 8'd20, 8'd10, 8'd41, 8'd29);
        queue_random(40);
        wait_drained();

        // overlapping bit windows
        set_windows(8'd150, 8'd200, 8'd10, 8'd40, 8'd30, 8'd60);
        queue_random(150);
        wait_drained();

        // back to defaults: long receiver hold with the sender running flat out
        set_windows(RST_PREAMBLE_MIN, RST_PREAMBLE_MAX, RST_ZERO_MIN, RST_ZERO_MAX,
                    RST_ONE_MIN, RST_ONE_MAX);
        no_idle = 1'b1;
        holds_asked++;
        queue_random(120);
        wait_drained();
        no_idle = 1'b0;
        queue_random(80);
        wait_drained();

        errors += expected_results.size();
        $display("Sent %0d items, checked %0d results, %0d of them with a frame done",
                 items_sent, results_seen, frames_done);
        $display("Windows: reset, random, widest, empty, overlapping; errors: %0d", errors);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
